### sv/csa_pkg.sv
package csa_pkg;

  localparam int unsigned SLOTS_DEF = 64;

  localparam int unsigned LEN_W  = 7;
  localparam int unsigned BASE_W = 6;

  typedef enum logic {
    KIND_ALLOC   = 1'b0,
    KIND_RELEASE = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } state_e;

  typedef struct packed {
    kind_e              kind;
    logic [LEN_W-1:0]   run_length;
    logic [BASE_W-1:0]  release_base;
  } req_t;

  typedef struct packed {
    logic               granted;
    logic [BASE_W-1:0]  base_index;
  } rsp_t;

endpackage

### sv/contiguous_slot_allocator_unit.sv
// First-fit contiguous slot allocator. One used bit per slot lives in a
// single-port-write, registered-read RAM. After reset the block walks the
// whole map clearing it, one slot per cycle, with busy high; items are
// taken only once busy drops. An allocate item scans the map from slot 0
// one slot per cycle through the RAM read port and a single run counter,
// then marks the found run one slot per cycle through the write port and
// then finishes. A release item clears its clipped run one slot per cycle.
// Each item gives exactly one result, shown on rsp_o for a single cycle
// with done_o high; the receiver cannot hold it off, so it must take the
// result in that cycle. busy is low whenever the block can accept a new
// item, including the cycle in which done_o is high.
module contiguous_slot_allocator_unit #(
  parameter int unsigned SLOTS = csa_pkg::SLOTS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  csa_pkg::req_t req_i,
  output logic          done_o,
  output csa_pkg::rsp_t rsp_o
);

  import csa_pkg::*;

  // slot address width and a counter width that holds SLOTS and any length
  localparam int unsigned AW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW0 = $clog2(SLOTS + 1);
  localparam int unsigned LW  = (CW0 > LEN_W) ? CW0 : LEN_W;

  state_e        state_q, state_d;
  logic [LW-1:0] ptr_q, ptr_d;      // read address in scan, write address otherwise
  logic [LW-1:0] rem_q, rem_d;      // slots left to write
  logic [LW-1:0] cnt_q, cnt_d;      // length of the current free run
  logic [LW-1:0] base_q, base_d;    // first slot of the current free run
  logic [LW-1:0] need_q, need_d;    // requested run length
  logic          wval_q, wval_d;    // value written: 1 mark, 0 release
  logic          vld_q, vld_d;      // read data in flight is for paddr_q
  logic [AW-1:0] paddr_q, paddr_d;
  logic          done_q, done_d;
  rsp_t          rsp_q, rsp_d;

  // map memory signals
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic          ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic          ram_rdata;

  logic [LW-1:0] cnt_inc;

  csa_ram #(
    .WIDTH (1),
    .DEPTH (SLOTS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      ptr_q   <= '0;
      vld_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      vld_q   <= vld_d;
      done_q  <= done_d;
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    cnt_q   <= cnt_d;
    base_q  <= base_d;
    need_q  <= need_d;
    wval_q  <= wval_d;
    paddr_q <= paddr_d;
    rsp_q   <= rsp_d;
  end

  assign cnt_inc = cnt_q + LW'(1);

  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    rem_d     = rem_q;
    cnt_d     = cnt_q;
    base_d    = base_q;
    need_d    = need_q;
    wval_d    = wval_q;
    vld_d     = 1'b0;
    paddr_d   = paddr_q;
    done_d    = 1'b0;
    rsp_d     = rsp_q;
    ram_we    = 1'b0;
    ram_waddr = ptr_q[AW-1:0];
    ram_wdata = wval_q;
    ram_raddr = ptr_q[AW-1:0];

    unique case (state_q)
      ST_CLEAR: begin
        // sweep the map to all free after reset
        ram_we    = 1'b1;
        ram_wdata = 1'b0;
        if (ptr_q == LW'(SLOTS - 1)) begin
          ptr_d   = '0;
          state_d = ST_IDLE;
        end else begin
          ptr_d = ptr_q + LW'(1);
        end
      end

      ST_IDLE: begin
        if (start) begin
          if (req_i.kind == KIND_ALLOC) begin
            ptr_d   = '0;
            cnt_d   = '0;
            base_d  = '0;
            need_d  = LW'(req_i.run_length);
            state_d = ST_SCAN;
          end else begin
            ptr_d   = LW'(req_i.release_base);
            rem_d   = LW'(req_i.run_length);
            wval_d  = 1'b0;
            rsp_d   = '{granted: 1'b1, base_index: '0};
            state_d = ST_WRITE;
          end
        end
      end

      ST_SCAN: begin
        // issue next read while judging the slot read last cycle
        ptr_d   = ptr_q + LW'(1);
        vld_d   = 1'b1;
        paddr_d = ptr_q[AW-1:0];
        if (vld_q) begin
          if (ram_rdata) begin
            cnt_d  = '0;
            base_d = LW'(paddr_q) + LW'(1);
          end else begin
            cnt_d = cnt_inc;
          end
          if (!ram_rdata && (cnt_inc >= need_q)) begin
            // run found, mark it
            vld_d   = 1'b0;
            ptr_d   = base_q;
            rem_d   = need_q;
            wval_d  = 1'b1;
            rsp_d   = '{granted: 1'b1, base_index: base_q[BASE_W-1:0]};
            state_d = ST_WRITE;
          end else if (paddr_q == AW'(SLOTS - 1)) begin
            vld_d   = 1'b0;
            rsp_d   = '{granted: 1'b0, base_index: '0};
            done_d  = 1'b1;
            state_d = ST_IDLE;
          end
        end
      end

      ST_WRITE: begin
        // shared run writer for marking and releasing, clipped at the end
        if ((rem_q != '0) && (ptr_q < LW'(SLOTS))) begin
          ram_we = 1'b1;
          ptr_d  = ptr_q + LW'(1);
          rem_d  = rem_q - LW'(1);
        end else begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

### sv/csa_ram.sv
module csa_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/csa_checker.sv
module csa_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input logic          done_o,
  input csa_pkg::rsp_t rsp_o
);

  import csa_pkg::*;

  // a result comes out only when the block is ready again
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while busy");

  // every accepted item makes the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("item accepted without going busy");

  // results are single-cycle strobes
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  // a failed allocation reports base zero
  a_fail_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !rsp_o.granted) |-> (rsp_o.base_index == '0))
    else $error("failed allocation with nonzero base");

endmodule

bind contiguous_slot_allocator_unit csa_checker u_csa_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);

### sim/tb_contiguous_slot_allocator_unit.sv
module tb_contiguous_slot_allocator_unit;
  import csa_pkg::*;

  localparam int unsigned SLOTS       = SLOTS_DEF;
  localparam int          RANDOM_ITEMS = 600;
  localparam int          QUIET_TAIL   = 60;
  // worst item: full scan plus a full-map write, plus sender gaps; taken many times over
  localparam int          CYCLE_LIMIT  = 500_000;
  localparam int          DRAIN_CYCLES = 2 * SLOTS + 8;
  localparam int          REQ_W        = $bits(req_t);

  // mirror of the slot map with the queue of pending answers
  class slot_map_scoreboard;
    bit          slot_used[SLOTS];
    rsp_t        pending_answers[$];
    int unsigned live_base[$];
    int unsigned live_len[$];
    int          errors;

    function new();
      foreach (slot_used[k]) slot_used[k] = 1'b0;
      errors = 0;
    endfunction

    // first fit from slot 0; a zero-length run lands on the lowest free slot
    function rsp_t serve_request(req_t r);
      rsp_t        ans;
      int unsigned need;
      int unsigned pos;
      int unsigned k;
      bit          found;
      bit          gave_up;
      bit          blocked;
      ans = '0;
      if (r.kind == KIND_ALLOC) begin
        need    = r.run_length;
        pos     = 0;
        found   = 1'b0;
        gave_up = 1'b0;
        while (pos < SLOTS && !found && !gave_up) begin
          if (slot_used[pos]) begin
            pos++;
          end else if (pos + need > SLOTS) begin
            gave_up = 1'b1;
          end else begin
            blocked = 1'b0;
            k = pos + 1;
            while (k < pos + need && !blocked) begin
              if (slot_used[k]) blocked = 1'b1;
              else k++;
            end
            if (blocked) pos = k + 1;
            else found = 1'b1;
          end
        end
        if (found) begin
          for (k = pos; k < pos + need; k++) slot_used[k] = 1'b1;
          ans.granted    = 1'b1;
          ans.base_index = pos[BASE_W-1:0];
          if (need > 0) begin
            live_base.push_back(pos);
            live_len.push_back(need);
            if (live_base.size() > SLOTS) begin
              void'(live_base.pop_front());
              void'(live_len.pop_front());
            end
          end
        end
      end else begin
        // clipped at the last slot, freeing free slots is harmless
        for (k = r.release_base; k < r.release_base + r.run_length && k < SLOTS; k++)
          slot_used[k] = 1'b0;
        ans.granted = 1'b1;
      end
      return ans;
    endfunction

    function void note_request(req_t r);
      pending_answers.push_back(serve_request(r));
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      if (pending_answers.size() == 0) begin
        $error("result with no pending item: granted %0d base_index %0d",
               got.granted, got.base_index);
        errors++;
        return;
      end
      want = pending_answers.pop_front();
      if (got.granted !== want.granted) begin
        $error("granted: expected %0d, got %0d", want.granted, got.granted);
        errors++;
      end
      if (got.base_index !== want.base_index) begin
        $error("base_index: expected %0d, got %0d", want.base_index, got.base_index);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_i;
  logic done_o;
  rsp_t rsp_o;

  slot_map_scoreboard sb = new();

  contiguous_slot_allocator_unit #(.SLOTS(SLOTS)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // results first, since the next item may be taken in the done cycle
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) sb.check_result(rsp_o);
      if (start && !busy) sb.note_request(req_i);
    end
  end

  function automatic req_t make_request(kind_e k, int unsigned len, int unsigned base);
    req_t r;
    r.kind         = k;
    r.run_length   = len[LEN_W-1:0];
    r.release_base = base[BASE_W-1:0];
    return r;
  endfunction

  task automatic drive_request(input req_t r);
    @(negedge clk_i);
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
  endtask

  // sender gap with junk on the request bus
  task automatic idle_burst(input int n);
    logic [REQ_W-1:0] noise;
    noise = REQ_W'($urandom);
    @(negedge clk_i);
    start <= 1'b0;
    req_i <= req_t'(noise);
    repeat (n - 1) @(negedge clk_i);
  endtask

  task automatic maybe_idle();
    if ($urandom_range(0, 3) == 0) idle_burst($urandom_range(1, 3));
  endtask

  // mostly small allocations and frees of live runs, some stray frees
  function automatic req_t random_request();
    int unsigned pick;
    int unsigned len;
    int unsigned idx;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      pick = $urandom_range(0, 99);
      if (pick < 70)      len = $urandom_range(1, 6);
      else if (pick < 90) len = $urandom_range(1, 16);
      else if (pick < 97) len = $urandom_range(17, 64);
      else                len = $urandom_range(0, 127);
      return make_request(KIND_ALLOC, len, $urandom_range(0, 63));
    end
    if (pick < 85 && sb.live_base.size() > 0) begin
      idx = $urandom_range(0, sb.live_base.size() - 1);
      make_request_live: begin
        req_t r;
        r = make_request(KIND_RELEASE, sb.live_len[idx], sb.live_base[idx]);
        sb.live_base.delete(idx);
        sb.live_len.delete(idx);
        return r;
      end
    end
    if ($urandom_range(0, 1) == 0) len = $urandom_range(0, 8);
    else len = $urandom_range(0, 127);
    return make_request(KIND_RELEASE, len, $urandom_range(0, 63));
  endfunction

  initial begin
    rst_ni = 1'b0;
    start  = 1'b0;
    req_i  = '0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty map, full map, clipping, zero lengths, fragmentation
    drive_request(make_request(KIND_ALLOC, 0, 0));
    drive_request(make_request(KIND_ALLOC, 64, 0));
    maybe_idle();
    drive_request(make_request(KIND_ALLOC, 1, 0));
    drive_request(make_request(KIND_ALLOC, 0, 0));
    drive_request(make_request(KIND_RELEASE, 127, 60));
    maybe_idle();
    drive_request(make_request(KIND_ALLOC, 5, 0));
    drive_request(make_request(KIND_ALLOC, 4, 63));
    drive_request(make_request(KIND_RELEASE, 0, 0));
    drive_request(make_request(KIND_RELEASE, 1, 63));
    maybe_idle();
    drive_request(make_request(KIND_ALLOC, 0, 0));
    drive_request(make_request(KIND_RELEASE, 3, 10));
    drive_request(make_request(KIND_ALLOC, 4, 0));
    drive_request(make_request(KIND_ALLOC, 3, 0));
    maybe_idle();
    drive_request(make_request(KIND_RELEASE, 127, 0));
    drive_request(make_request(KIND_RELEASE, 5, 5));
    drive_request(make_request(KIND_ALLOC, 65, 0));
    drive_request(make_request(KIND_ALLOC, 127, 0));
    maybe_idle();
    drive_request(make_request(KIND_ALLOC, 64, 0));
    drive_request(make_request(KIND_RELEASE, 64, 0));
    drive_request(make_request(KIND_ALLOC, 63, 0));
    drive_request(make_request(KIND_ALLOC, 1, 0));
    drive_request(make_request(KIND_RELEASE, 1, 32));
    drive_request(make_request(KIND_ALLOC, 2, 0));
    drive_request(make_request(KIND_RELEASE, 127, 0));

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i < RANDOM_ITEMS - QUIET_TAIL) maybe_idle();
      drive_request(random_request());
    end

    @(negedge clk_i);
    start <= 1'b0;
    while (sb.pending_answers.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.errors == 0 && sb.pending_answers.size() == 0) begin
      $display("contiguous_slot_allocator_unit regression: pass");
    end else begin
      $display("contiguous_slot_allocator_unit regression: fail");
    end
    $finish;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("contiguous_slot_allocator_unit regression: fail");
    $finish;
  end

endmodule
